// ----- hw/rtl/lcdmt_pkg.sv -----
`default_nettype none

package lcdmt_pkg;

  // Output mode codes
  localparam logic [1:0] LCD_MODE_HBLANK = 2'd0;
  localparam logic [1:0] LCD_MODE_VBLANK = 2'd1;
  localparam logic [1:0] LCD_MODE_OAM    = 2'd2;
  localparam logic [1:0] LCD_MODE_VRAM   = 2'd3;

  // Mode durations in CPU ticks
  localparam logic [31:0] TICKS_HBLANK      = 32'd204;
  localparam logic [31:0] TICKS_VBLANK_LINE = 32'd456;
  localparam logic [31:0] TICKS_OAM         = 32'd80;
  localparam logic [31:0] TICKS_VRAM        = 32'd172;
  localparam logic [31:0] TICKS_OAM_VRAM    = TICKS_OAM + TICKS_VRAM;

  // Scanline marks
  localparam logic [7:0] LINE_ENTER_VBLANK = 8'd143;
  localparam logic [7:0] LINE_LAST         = 8'd153;

  // LCD timing state machine, one-hot
  typedef enum logic [3:0] {
    MODE_HBLANK = 4'b0001,
    MODE_VBLANK = 4'b0010,
    MODE_OAM    = 4'b0100,
    MODE_VRAM   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [31:0] acc;
    mode_t       mode;
    logic [7:0]  line;
  } lcdmt_state_t;

  typedef struct packed {
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic       vblank_request;
  } lcdmt_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcdmt_if.sv -----
`default_nettype none

// Tick update channel
interface lcdmt_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] cpu_ticks;
  logic        vblank_enable;

  modport source (output valid, output cpu_ticks, output vblank_enable, input ready);
  modport sink   (input valid, input cpu_ticks, input vblank_enable, output ready);
endinterface

// Mode status channel
interface lcdmt_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] lcd_mode;
  logic [7:0] line_number;
  logic       vblank_request;

  modport source (output valid, output lcd_mode, output line_number,
                  output vblank_request, input ready);
  modport sink   (input valid, input lcd_mode, input line_number,
                  input vblank_request, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lcdmt_step.sv -----
`default_nettype none

// One timing step: saturating accumulate, then one mode transition
module lcdmt_step
  import lcdmt_pkg::*;
(
  input  lcdmt_state_t  state,
  input  logic [31:0]   elapsed,
  input  logic          enable,
  output lcdmt_state_t  state_next,
  output lcdmt_result_t result
);

  logic [32:0] sum;
  logic [31:0] acc_sat;
  logic [7:0]  line_inc;
  logic        request;

  // Saturating accumulate
  always_comb begin
    sum     = {1'b0, state.acc} + {1'b0, elapsed};
    acc_sat = sum[32] ? '1 : sum[31:0];
    line_inc = state.line + 8'd1;
  end

  // Mode step; OAM may run on through VRAM in the same step
  always_comb begin
    state_next = state;
    state_next.acc = acc_sat;
    request = 1'b0;
    case (state.mode)
      MODE_HBLANK: begin
        if (acc_sat >= TICKS_HBLANK) begin
          state_next.line = line_inc;
          state_next.acc  = acc_sat - TICKS_HBLANK;
          if (line_inc == LINE_ENTER_VBLANK) begin
            state_next.mode = MODE_VBLANK;
            request = enable;
          end else begin
            state_next.mode = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (acc_sat >= TICKS_VBLANK_LINE) begin
          state_next.acc  = acc_sat - TICKS_VBLANK_LINE;
          state_next.line = line_inc;
          if (line_inc > LINE_LAST) begin
            state_next.line = 8'd0;
            state_next.mode = MODE_OAM;
          end
        end
      end
      MODE_OAM: begin
        if (acc_sat >= TICKS_OAM_VRAM) begin
          state_next.mode = MODE_HBLANK;
          state_next.acc  = acc_sat - TICKS_OAM_VRAM;
        end else if (acc_sat >= TICKS_OAM) begin
          state_next.mode = MODE_VRAM;
          state_next.acc  = acc_sat - TICKS_OAM;
        end
      end
      default: begin
        if (acc_sat >= TICKS_VRAM) begin
          state_next.mode = MODE_HBLANK;
          state_next.acc  = acc_sat - TICKS_VRAM;
        end
      end
    endcase
  end

  // Encode the result
  always_comb begin
    case (state_next.mode)
      MODE_HBLANK: result.lcd_mode = LCD_MODE_HBLANK;
      MODE_VBLANK: result.lcd_mode = LCD_MODE_VBLANK;
      MODE_OAM:    result.lcd_mode = LCD_MODE_OAM;
      default:     result.lcd_mode = LCD_MODE_VRAM;
    endcase
    result.line_number    = state_next.line;
    result.vblank_request = request;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lcd_mode_timing_sequencer.sv -----
`default_nettype none

// Channel  Dir  Payload                                     Per transfer
// ticks    in   cpu_ticks[31:0], vblank_enable              one tick update
// status   out  lcd_mode[1:0], line_number[7:0],            one status
//              vblank_request
//
// Two register stages: the input stage holds the elapsed tick count, the
// output stage holds the status after the mode step. One update per cycle
// while status is not stalled, through the input then the output stage.
// Reset (rst, synchronous) clears the accumulator, last tick count, line and
// sets HBlank. A stalled status output holds every full stage in place.

module lcd_mode_timing_sequencer
  import lcdmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  lcdmt_tick_if.sink    ticks,
  lcdmt_status_if.source status
);

  logic          s1_valid;
  logic [31:0]   s1_elapsed;
  logic          s1_enable;
  logic [31:0]   previous_ticks;
  logic          s1_advance;

  lcdmt_state_t  state;
  lcdmt_state_t  state_next;
  lcdmt_result_t result_next;
  lcdmt_result_t result;
  logic          out_valid;

  // Pipeline flow control
  assign s1_advance  = s1_valid && (!out_valid || status.ready);
  assign ticks.ready = !s1_valid || s1_advance;

  // Input stage: elapsed ticks, wrapping difference
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      previous_ticks <= '0;
    end else begin
      if (ticks.valid && ticks.ready) begin
        s1_valid       <= 1'b1;
        previous_ticks <= ticks.cpu_ticks;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ticks.valid && ticks.ready) begin
      s1_elapsed <= ticks.cpu_ticks - previous_ticks;
      s1_enable  <= ticks.vblank_enable;
    end
  end

  lcdmt_step u_step (
    .state      (state),
    .elapsed    (s1_elapsed),
    .enable     (s1_enable),
    .state_next (state_next),
    .result     (result_next)
  );

  // Timing state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.acc  <= '0;
      state.mode <= MODE_HBLANK;
      state.line <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

  assign status.valid          = out_valid;
  assign status.lcd_mode       = result.lcd_mode;
  assign status.line_number    = result.line_number;
  assign status.vblank_request = result.vblank_request;

endmodule

`default_nettype wire

// ----- dv/lcdmt_checker.sv -----
module lcdmt_checker
  import lcdmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lcdmt_tick_if       ticks,
  lcdmt_status_if     status,
  output int unsigned fail_count,
  output int unsigned pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the timing machine
  logic [31:0] acc_ticks;
  logic [31:0] last_ticks;
  logic [1:0]  mode_code;
  logic [7:0]  scanline;

  // Status words owed by the block, oldest first
  lcdmt_result_t status_owed_q[$];

  // Advance the shadow machine by one tick update and return the status it shows
  function automatic lcdmt_result_t step_lcd_timing(input logic [31:0] now,
                                                    input logic irq_en);
    logic [31:0]   elapsed;
    lcdmt_result_t res;
    elapsed = now - last_ticks;  // wraps with the counter
    res.vblank_request = 1'b0;

    // Saturating add: headroom is the bitwise inverse
    if (elapsed > ~acc_ticks) acc_ticks = '1;
    else acc_ticks = acc_ticks + elapsed;
    last_ticks = now;

    case (mode_code)
      LCD_MODE_HBLANK: begin
        if (acc_ticks >= TICKS_HBLANK) begin
          scanline = scanline + 8'd1;
          if (scanline == LINE_ENTER_VBLANK) begin
            res.vblank_request = irq_en;
            mode_code = LCD_MODE_VBLANK;
          end else begin
            mode_code = LCD_MODE_OAM;
          end
          acc_ticks = acc_ticks - TICKS_HBLANK;
        end
      end
      LCD_MODE_VBLANK: begin
        if (acc_ticks >= TICKS_VBLANK_LINE) begin
          scanline = scanline + 8'd1;
          if (scanline > LINE_LAST) begin
            scanline = 8'd0;
            mode_code = LCD_MODE_OAM;
          end
          acc_ticks = acc_ticks - TICKS_VBLANK_LINE;
        end
      end
      LCD_MODE_OAM: begin
        // OAM check falls through into the VRAM check
        if (acc_ticks >= TICKS_OAM) begin
          mode_code = LCD_MODE_VRAM;
          acc_ticks = acc_ticks - TICKS_OAM;
        end
        if (acc_ticks >= TICKS_VRAM) begin
          mode_code = LCD_MODE_HBLANK;
          acc_ticks = acc_ticks - TICKS_VRAM;
        end
      end
      default: begin
        if (acc_ticks >= TICKS_VRAM) begin
          mode_code = LCD_MODE_HBLANK;
          acc_ticks = acc_ticks - TICKS_VRAM;
        end
      end
    endcase

    res.lcd_mode    = mode_code;
    res.line_number = scanline;
    return res;
  endfunction

  // Watch both channels: compare status transfers, predict on tick transfers
  always @(posedge clk) begin
    lcdmt_result_t want;
    if (rst) begin
      acc_ticks  = '0;
      last_ticks = '0;
      mode_code  = LCD_MODE_HBLANK;
      scanline   = '0;
      status_owed_q.delete();
      fail_count = 0;
      pending_count <= 0;
    end else begin
      if (status.valid && status.ready) begin
        if (status_owed_q.size() == 0) begin
          $error("status transfer with no tick update outstanding");
          fail_count++;
        end else begin
          want = status_owed_q.pop_front();
          if (status.lcd_mode !== want.lcd_mode) begin
            $error("lcd_mode: expected %0d, actual %0d", want.lcd_mode, status.lcd_mode);
            fail_count++;
          end
          if (status.line_number !== want.line_number) begin
            $error("line_number: expected %0d, actual %0d",
                   want.line_number, status.line_number);
            fail_count++;
          end
          if (status.vblank_request !== want.vblank_request) begin
            $error("vblank_request: expected %0d, actual %0d",
                   want.vblank_request, status.vblank_request);
            fail_count++;
          end
        end
      end
      if (ticks.valid && ticks.ready)
        status_owed_q.push_back(step_lcd_timing(ticks.cpu_ticks, ticks.vblank_enable));
      pending_count <= status_owed_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import lcdmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 8;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending_count;

  lcdmt_tick_if   tick_ch();
  lcdmt_status_if status_ch();

  lcd_mode_timing_sequencer dut (
    .clk    (clk),
    .rst    (rst),
    .ticks  (tick_ch),
    .status (status_ch)
  );

  lcdmt_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .ticks         (tick_ch),
    .status        (status_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Watchdog: cycles since the last transfer on either channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (status_ch.valid && status_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Status sink: mostly ready, short and long stalls, some steady stretches
  int unsigned sink_calm  = 0;
  int unsigned sink_stall = 0;
  int unsigned sink_roll;
  always @(negedge clk) begin
    if (sink_calm > 0) begin
      sink_calm--;
      status_ch.ready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      status_ch.ready <= 1'b0;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 2) sink_calm = $urandom_range(40, 120);
      else if (sink_roll < 6) sink_stall = $urandom_range(10, 40);
      else if (sink_roll < 30) sink_stall = $urandom_range(1, 3);
      status_ch.ready <= (sink_roll < 2) || (sink_roll >= 30);
    end
  end

  // Tick source state
  logic [31:0] tick_now = '0;
  int unsigned item_count = 0;
  int unsigned src_calm = 0;
  int unsigned src_roll;
  logic [31:0] tick_marks [5] = '{TICKS_OAM, TICKS_VRAM, TICKS_HBLANK,
                                  TICKS_OAM_VRAM, TICKS_VBLANK_LINE};
  logic [31:0] wrap_points [8] = '{32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFFF,
                                   32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                   32'hFFFF_FFFE, 32'hFFFF_FFFE};
  logic [31:0] small_deltas [13] = '{0, 203, 1, 79, 1, 171, 1, 204, 252,
                                     300, 0, 155, 0};

  // Interrupt enable held in windows of 128 updates, with occasional flips
  function automatic logic window_enable();
    return item_count[7] ^ ($urandom_range(0, 9) == 0);
  endfunction

  // One tick-update transfer, after a random gap
  task automatic send_tick(input logic [31:0] t, input logic en);
    int unsigned gap;
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      src_roll = $urandom_range(0, 99);
      if (src_roll < 2) src_calm = $urandom_range(30, 80);
      if (src_roll < 55) gap = 0;
      else if (src_roll < 85) gap = $urandom_range(1, 3);
      else if (src_roll < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
    end
    repeat (gap) begin
      @(negedge clk);
      tick_ch.valid         <= 1'b0;
      tick_ch.cpu_ticks     <= $urandom;
      tick_ch.vblank_enable <= 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    tick_ch.valid         <= 1'b1;
    tick_ch.cpu_ticks     <= t;
    tick_ch.vblank_enable <= en;
    do @(posedge clk); while (!tick_ch.ready);
    item_count++;
  endtask

  // Stop sending until every status owed has been transferred
  task automatic hold_until_drained();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    rst                   = 1'b1;
    tick_ch.valid         = 1'b0;
    tick_ch.cpu_ticks     = '0;
    tick_ch.vblank_enable = 1'b0;
    status_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Exact mode boundaries and OAM fall-through with small steps
    foreach (small_deltas[i]) begin
      tick_now += small_deltas[i];
      send_tick(tick_now, i[0]);
    end

    // Realistic pacing: accumulator stays small, runs into VBlank
    repeat (450) begin
      src_roll = $urandom_range(0, 99);
      if (src_roll < 50) tick_now += $urandom_range(0, 100);
      else if (src_roll < 80) tick_now += $urandom_range(100, 300);
      else if (src_roll < 90) tick_now += tick_marks[$urandom_range(0, 4)];
      else tick_now += $urandom_range(300, 1000);
      send_tick(tick_now, window_enable());
    end
    hold_until_drained();

    // Counter wrap and accumulator saturation
    foreach (wrap_points[i]) begin
      tick_now = wrap_points[i];
      send_tick(tick_now, !i[0]);
    end

    // Saturated accumulator: one transition per step, full-range counter values
    repeat (420) begin
      src_roll = $urandom_range(0, 99);
      if (src_roll < 40) tick_now = $urandom;
      else if (src_roll < 80) tick_now += $urandom_range(0, 500);
      else tick_now -= $urandom_range(1, 500);
      send_tick(tick_now, window_enable());
    end
    hold_until_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/lcdmt_pkg.sv
hw/rtl/lcdmt_if.sv
hw/rtl/lcdmt_step.sv
hw/rtl/lcd_mode_timing_sequencer.sv
dv/lcdmt_checker.sv
dv/tb.sv
